// ===== rtl/lpcm_pkg.sv =====
// Shared types and constants for the lambda protection cut monitor.
`timescale 1ns / 1ps
`default_nettype none

package lpcm_pkg;

    localparam int unsigned RPM_W    = 15;
    localparam int unsigned LOAD_W   = 12;
    localparam int unsigned TPS_W    = 10;
    localparam int unsigned LAMBDA_W = 12;
    localparam int unsigned DEV_W    = 10;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned ELAP_W   = 10;

    localparam int unsigned S_TDATA_W = 120;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [MS_W-1:0] TIMER_MAX = '1;
    localparam logic [MS_W-1:0] TIMEOUT_RESET = 16'd500;

    localparam int unsigned OVERRUN_PAUSE_MS_DEF   = 1000;
    localparam int unsigned OTHER_CUT_PAUSE_MS_DEF = 2000;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_PROTECT_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RPM        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LOAD       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TPS        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE_RPM    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE_LOAD   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE_TPS    = 4'd7;

    typedef struct packed {
        logic                protect_enable;
        logic [RPM_W-1:0]    min_rpm;
        logic [LOAD_W-1:0]   min_load;
        logic [TPS_W-1:0]    min_tps;
        logic [MS_W-1:0]     timeout_ms;
        logic [RPM_W-1:0]    restore_rpm;
        logic [LOAD_W-1:0]   restore_load;
        logic [TPS_W-1:0]    restore_tps;
    } cfg_t;

    typedef struct packed {
        logic [RPM_W-1:0]    engine_rpm;
        logic [LOAD_W-1:0]   engine_load;
        logic [TPS_W-1:0]    throttle_pos;
        logic [LAMBDA_W-1:0] lambda_reading;
        logic                lambda_valid;
        logic [LAMBDA_W-1:0] target_lambda;
        logic [DEV_W-1:0]    max_deviation;
        logic [MS_W-1:0]     since_overrun_ms;
        logic [MS_W-1:0]     since_other_cut_ms;
        logic [ELAP_W-1:0]   elapsed_ms;
    } item_t;

    typedef struct packed {
        logic                cut_active;
        logic                lambda_good;
        logic [MS_W-1:0]     time_since_good_ms;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/lpcm_cfg.sv =====
// Configuration register file for the lambda protection cut monitor.
`timescale 1ns / 1ps
`default_nettype none

module lpcm_cfg (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    input  wire logic [lpcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lpcm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output lpcm_pkg::cfg_t                            cfg_out
);

    lpcm_pkg::cfg_t cfg_reg;
    lpcm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lpcm_pkg::REG_PROTECT_ENABLE: cfg_next.protect_enable = cfg_data[0];
                lpcm_pkg::REG_MIN_RPM:      cfg_next.min_rpm = cfg_data[lpcm_pkg::RPM_W-1:0];
                lpcm_pkg::REG_MIN_LOAD:     cfg_next.min_load = cfg_data[lpcm_pkg::LOAD_W-1:0];
                lpcm_pkg::REG_MIN_TPS:      cfg_next.min_tps = cfg_data[lpcm_pkg::TPS_W-1:0];
                lpcm_pkg::REG_TIMEOUT_MS:   cfg_next.timeout_ms = cfg_data[lpcm_pkg::MS_W-1:0];
                lpcm_pkg::REG_RESTORE_RPM:  cfg_next.restore_rpm = cfg_data[lpcm_pkg::RPM_W-1:0];
                lpcm_pkg::REG_RESTORE_LOAD: cfg_next.restore_load = cfg_data[lpcm_pkg::LOAD_W-1:0];
                lpcm_pkg::REG_RESTORE_TPS:  cfg_next.restore_tps = cfg_data[lpcm_pkg::TPS_W-1:0];
                default: ; // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg            <= '0;
            cfg_reg.timeout_ms <= lpcm_pkg::TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/lpcm_core.sv =====
// Sample evaluation, bad-lambda timer and cut latch.
`timescale 1ns / 1ps
`default_nettype none

module lpcm_core #(
    parameter int unsigned OVERRUN_PAUSE_MS   = lpcm_pkg::OVERRUN_PAUSE_MS_DEF,
    parameter int unsigned OTHER_CUT_PAUSE_MS = lpcm_pkg::OTHER_CUT_PAUSE_MS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,      // commit the item below
    input  wire lpcm_pkg::item_t item,
    input  wire lpcm_pkg::cfg_t  cfg,
    output lpcm_pkg::result_t    result,
    output logic                 cut_state
);

    localparam logic [lpcm_pkg::MS_W-1:0] OVR_PAUSE =
        lpcm_pkg::MS_W'(OVERRUN_PAUSE_MS);
    localparam logic [lpcm_pkg::MS_W-1:0] OTHER_PAUSE =
        lpcm_pkg::MS_W'(OTHER_CUT_PAUSE_MS);

    logic [lpcm_pkg::MS_W-1:0]     timer_reg, timer_next;
    logic                          cut_reg, cut_next;
    logic                          good;
    logic [lpcm_pkg::LAMBDA_W:0]   lean_limit;
    logic [lpcm_pkg::MS_W:0]       timer_sum;
    logic [lpcm_pkg::MS_W-1:0]     reported;
    logic                          latched;
    logic                          restore;

    always_comb begin
        lean_limit = {1'b0, item.target_lambda}
                   + {{(lpcm_pkg::LAMBDA_W + 1 - lpcm_pkg::DEV_W){1'b0}}, item.max_deviation};
        good = !cfg.protect_enable
            || (item.engine_rpm < cfg.min_rpm)
            || (item.engine_load < cfg.min_load)
            || (item.throttle_pos <= cfg.min_tps)
            || (item.since_overrun_ms < OVR_PAUSE)
            || (item.since_other_cut_ms < OTHER_PAUSE)
            || !item.lambda_valid
            || ({1'b0, item.lambda_reading} < lean_limit);

        timer_sum = {1'b0, timer_reg}
                  + {{(lpcm_pkg::MS_W + 1 - lpcm_pkg::ELAP_W){1'b0}}, item.elapsed_ms};
        if (good) begin
            reported = '0;
        end else if (timer_sum[lpcm_pkg::MS_W]) begin
            reported = lpcm_pkg::TIMER_MAX;
        end else begin
            reported = timer_sum[lpcm_pkg::MS_W-1:0];
        end

        latched = cut_reg || (reported > cfg.timeout_ms);
        restore = (item.engine_rpm <= cfg.restore_rpm)
               && (item.engine_load <= cfg.restore_load)
               && (item.throttle_pos <= cfg.restore_tps);

        // release clears both latch and timer; the report keeps the pre-release value
        cut_next   = latched && !restore;
        timer_next = (latched && restore) ? '0 : reported;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            cut_reg   <= 1'b0;
        end else if (step) begin
            timer_reg <= timer_next;
            cut_reg   <= cut_next;
        end
    end

    assign result.cut_active         = cut_next;
    assign result.lambda_good        = good;
    assign result.time_since_good_ms = reported;
    assign cut_state                 = cut_reg;

endmodule

`default_nettype wire

// ===== rtl/lambda_protection_cut_monitor.sv =====
// Top level of the lambda protection cut monitor.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  s_       | s_tvalid / s_tready | s_tdata: sensor update, s_tuser: lambda_valid
//  m_       | m_tvalid / m_tready | m_tdata: cut_active, lambda_good, timer
//  cfg_     | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// One beat per cycle sustained while m_tready is high; an input beat goes to the
// input register, then through evaluation into the output register as its result.
// The timer and latch advance as a beat moves into the output register.
// Reset clears timer, latch, both stages; config returns to defaults.
// With m_tready low the result holds, one more beat is taken, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module lambda_protection_cut_monitor #(
    parameter int unsigned OVERRUN_PAUSE_MS   = lpcm_pkg::OVERRUN_PAUSE_MS_DEF,
    parameter int unsigned OTHER_CUT_PAUSE_MS = lpcm_pkg::OTHER_CUT_PAUSE_MS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // engine_rpm, engine_load, throttle_pos, lambda_reading, target_lambda,
    // max_deviation, since_overrun_ms, since_other_cut_ms, elapsed_ms, zero pad
    input  wire logic [lpcm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tuser,  // lambda_valid
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // cut_active, lambda_good, time_since_good_ms, zero pad
    output logic [lpcm_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lpcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lpcm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lpcm_pkg::cfg_t    cfg;
    lpcm_pkg::item_t   in_item_reg, in_item_next;
    logic              in_valid_reg;
    lpcm_pkg::result_t result;
    lpcm_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              out_load;
    logic              in_load;
    logic              cut_state;

    assign cfg_ready = 1'b1;

    lpcm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    always_comb begin
        in_item_next.engine_rpm         = s_tdata[14:0];
        in_item_next.engine_load        = s_tdata[26:15];
        in_item_next.throttle_pos       = s_tdata[36:27];
        in_item_next.lambda_reading     = s_tdata[48:37];
        in_item_next.lambda_valid       = s_tuser;
        in_item_next.target_lambda      = s_tdata[60:49];
        in_item_next.max_deviation      = s_tdata[70:61];
        in_item_next.since_overrun_ms   = s_tdata[86:71];
        in_item_next.since_other_cut_ms = s_tdata[102:87];
        in_item_next.elapsed_ms         = s_tdata[112:103];
    end

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    lpcm_core #(
        .OVERRUN_PAUSE_MS   (OVERRUN_PAUSE_MS),
        .OTHER_CUT_PAUSE_MS (OTHER_CUT_PAUSE_MS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (out_load),
        .item      (in_item_reg),
        .cfg       (cfg),
        .result    (result),
        .cut_state (cut_state)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= in_item_next;
        end
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.time_since_good_ms, out_reg.lambda_good,
                       out_reg.cut_active};

`ifndef ASSERT_OFF
    // a good sample always reports a cleared timer
    a_good_clears_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[17:2] == 16'd0)
        else $error("good sample with nonzero timer");

    // input side only stalls when the output beat is stuck
    a_stall_only_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready && in_valid_reg)
        else $error("input stalled without output backpressure");

    // reported cut matches the latch state it leaves behind
    a_cut_tracks_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tdata[0] == cut_state)
        else $error("cut_active disagrees with latch");
`endif

endmodule

`default_nettype wire
